[rtl/md4_pkg.sv]
// ----------------------------------------------------------------------------
// md4_pkg
// Shared types, constants and round functions of the MD4 digest block.
// ----------------------------------------------------------------------------
package md4_pkg;

    localparam int WORD_W     = 32;
    localparam int BLOCK_W    = 16;
    localparam int ROUND_W    = 6;
    localparam int FILL_W     = 6;
    localparam int LENGTH_W   = 64;
    localparam int DIGEST_W   = 128;

    localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
    localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] INIT_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;
    localparam logic [WORD_W-1:0] K_ROUND2 = 32'h5a827999;
    localparam logic [WORD_W-1:0] K_ROUND3 = 32'h6ed9eba1;

    localparam logic [7:0]         PAD_BYTE    = 8'h80;
    localparam logic [FILL_W-1:0]  LENGTH_SLOT = 6'd56;
    localparam logic [FILL_W-1:0]  FILL_LAST   = 6'd63;
    localparam logic [ROUND_W-1:0] ROUND_LAST  = 6'd47;
    localparam logic [3:0]         LEN_WORD_LO = 4'd14;
    localparam logic [3:0]         LEN_WORD_HI = 4'd15;
    localparam logic [LENGTH_W-1:0] BITS_PER_BYTE = 64'd8;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ROUND  = 5'b00010,
        ST_FOLD   = 5'b00100,
        ST_LENGTH = 5'b01000,
        ST_OUTPUT = 5'b10000
    } state_t;

    typedef struct packed {
        logic               load_byte;
        logic               pad;
        logic               load_len;
        logic               load_v;
        logic               round_en;
        logic [ROUND_W-1:0] round_idx;
        logic               fold;
        logic               emit;
    } md4_cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              out_free;
    } md4_status_t;

    // Index of the message word used by a step.
    function automatic logic [3:0] msg_index(input logic [ROUND_W-1:0] idx);
        logic [3:0] j;
        logic [3:0] m;
        j = idx[3:0];
        case (idx[5:4])
            2'd0:    m = j;
            2'd1:    m = {j[1:0], j[3:2]};
            default: m = {j[0], j[1], j[2], j[3]};
        endcase
        return m;
    endfunction

    function automatic logic [4:0] shift_amount(input logic [ROUND_W-1:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'b0000: s = 5'd3;
            4'b0001: s = 5'd7;
            4'b0010: s = 5'd11;
            4'b0011: s = 5'd19;
            4'b0100: s = 5'd3;
            4'b0101: s = 5'd5;
            4'b0110: s = 5'd9;
            4'b0111: s = 5'd13;
            4'b1000: s = 5'd3;
            4'b1001: s = 5'd9;
            4'b1010: s = 5'd11;
            4'b1011: s = 5'd15;
            default: s = 5'd3;
        endcase
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input logic [4:0] s);
        logic [2*WORD_W-1:0] tmp;
        tmp = {x, x} << s;
        return tmp[2*WORD_W-1:WORD_W];
    endfunction

    // One MD4 step: new value of the slot being updated.
    function automatic logic [WORD_W-1:0] md4_step(
        input logic [WORD_W-1:0]  a,
        input logic [WORD_W-1:0]  x,
        input logic [WORD_W-1:0]  y,
        input logic [WORD_W-1:0]  z,
        input logic [WORD_W-1:0]  w,
        input logic [ROUND_W-1:0] idx
    );
        logic [WORD_W-1:0] f;
        logic [WORD_W-1:0] k;
        case (idx[5:4])
            2'd0: begin
                f = z ^ (x & (y ^ z));
                k = '0;
            end
            2'd1: begin
                f = (x & y) | (x & z) | (y & z);
                k = K_ROUND2;
            end
            default: begin
                f = x ^ y ^ z;
                k = K_ROUND3;
            end
        endcase
        return rotl(a + f + w + k, shift_amount(idx));
    endfunction

endpackage

[rtl/md4_message_digest.sv]
// ----------------------------------------------------------------------------
// md4_message_digest
// MD4 digest of a byte stream, one byte per input transaction.
// ----------------------------------------------------------------------------
// Send message bytes with s_tuser low; send one transaction with s_tuser high
// to pad the message, append its bit length and return the 16-byte digest on
// the m_ side, after which the block starts a new message. A byte is taken
// whenever the block is idle, but the 64th byte of a block holds s_tready low
// while the block is compressed: one shared step unit runs the 48 MD4 steps,
// one per cycle, and a fold state then adds the result into the chaining
// value. A finish compresses one block, or two when 56 or more bytes of the
// last block are already filled and the pad needs a block of its own, and
// waits for a previous digest to be taken before it emits. The digest
// sits in an output register, so new message bytes are accepted while it
// waits on m_tready.
// ----------------------------------------------------------------------------
module md4_message_digest
    import md4_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] message_byte
    input  logic                s_tuser,   // [0] command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DIGEST_W-1:0] m_tdata    // [63:0] digest_first, [127:64] digest_second
);

    md4_cmd_t    cmd;
    md4_status_t status;

    md4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    md4_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .byte_in  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .status   (status)
    );

endmodule

[rtl/md4_ctrl.sv]
// ----------------------------------------------------------------------------
// md4_ctrl
// Sequencer: absorb, padding, length, 48-step compression and digest output.
// ----------------------------------------------------------------------------
module md4_ctrl
    import md4_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tuser,
    output logic        s_tready,
    input  md4_status_t status,
    output md4_cmd_t    cmd
);

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [ROUND_W-1:0] round_reg, round_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        round_next    = round_reg;
        cmd           = '0;
        cmd.round_idx = round_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser) begin
                        cmd.load_byte = 1'b1;
                        if (status.fill == FILL_LAST) begin
                            cmd.load_v = 1'b1;
                            ret_next   = ST_IDLE;
                            round_next = '0;
                            state_next = ST_ROUND;
                        end
                    end else begin
                        cmd.pad = 1'b1;
                        if (status.fill >= LENGTH_SLOT) begin
                            // no room for the length: compress the pad block first
                            cmd.load_v = 1'b1;
                            ret_next   = ST_LENGTH;
                            round_next = '0;
                            state_next = ST_ROUND;
                        end else begin
                            state_next = ST_LENGTH;
                        end
                    end
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_FOLD;
                end else begin
                    round_next = round_reg + 1'b1;
                end
            end
            ST_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
            end
            ST_LENGTH: begin
                cmd.load_len = 1'b1;
                cmd.load_v   = 1'b1;
                ret_next     = ST_OUTPUT;
                round_next   = '0;
                state_next   = ST_ROUND;
            end
            ST_OUTPUT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/md4_datapath.sv]
// ----------------------------------------------------------------------------
// md4_datapath
// Block buffer, bit length, chaining value, round registers and digest output.
// ----------------------------------------------------------------------------
module md4_datapath
    import md4_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  md4_cmd_t            cmd,
    input  logic [7:0]          byte_in,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [DIGEST_W-1:0] m_tdata,
    output md4_status_t         status
);

    logic [WORD_W-1:0]   buf_reg [BLOCK_W];
    logic [WORD_W-1:0]   chain_reg [4];
    logic [WORD_W-1:0]   v_reg [4];
    logic [FILL_W-1:0]   fill_reg;
    logic [LENGTH_W-1:0] len_reg;
    logic [DIGEST_W-1:0] digest_reg;
    logic                out_valid_reg;

    logic [7:0]          wr_byte;
    logic [4:0]          lane_base;
    logic [WORD_W-1:0]   msg_word;
    logic [WORD_W-1:0]   step_next;

    assign wr_byte   = cmd.pad ? PAD_BYTE : byte_in;
    assign lane_base = {fill_reg[1:0], 3'b000};
    assign msg_word  = buf_reg[msg_index(cmd.round_idx)];
    assign step_next = md4_step(v_reg[0], v_reg[1], v_reg[2], v_reg[3], msg_word,
                                cmd.round_idx);

    // Block buffer, fill count and bit length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BLOCK_W; i++) buf_reg[i] <= '0;
            fill_reg <= '0;
            len_reg  <= '0;
        end else begin
            if (cmd.fold) begin
                for (int i = 0; i < BLOCK_W; i++) buf_reg[i] <= '0;
                fill_reg <= '0;
            end else begin
                if (cmd.load_byte || cmd.pad) begin
                    buf_reg[fill_reg[5:2]][lane_base +: 8] <= wr_byte;
                end
                if (cmd.load_len) begin
                    buf_reg[LEN_WORD_LO] <= len_reg[WORD_W-1:0];
                    buf_reg[LEN_WORD_HI] <= len_reg[LENGTH_W-1:WORD_W];
                end
                if (cmd.load_byte) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.load_byte) begin
                len_reg <= len_reg + BITS_PER_BYTE;
            end else if (cmd.emit) begin
                len_reg <= '0;
            end
        end
    end

    // Chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end else if (cmd.emit) begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end else if (cmd.fold) begin
            for (int i = 0; i < 4; i++) chain_reg[i] <= chain_reg[i] + v_reg[i];
        end
    end

    // Working registers; slot 0 is always the one being updated, so
    // rotate by one slot per step (back in A, B, C, D order after 48 steps)
    always_ff @(posedge aclk) begin
        if (cmd.load_v) begin
            for (int i = 0; i < 4; i++) v_reg[i] <= chain_reg[i];
        end else if (cmd.round_en) begin
            v_reg[0] <= v_reg[3];
            v_reg[1] <= step_next;
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            digest_reg <= {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = digest_reg;
    assign status.fill     = fill_reg;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

[rtl/md4_checker.sv]
// ----------------------------------------------------------------------------
// md4_checker
// Port-level checks of the MD4 digest block, bound to its top level.
// ----------------------------------------------------------------------------
module md4_checker
    import md4_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [DIGEST_W-1:0] m_tdata
);

    // no digest right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("digest valid after reset");

    // a finish always stalls the input while the digest is computed
    a_finish_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input accepted right after finish");

    // a digest appears only from the output state, never during absorb
    a_digest_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("digest appeared while input was open");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled digest dropped or changed");

endmodule

bind md4_message_digest md4_checker u_md4_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/tb_md4_message_digest.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_md4_message_digest
// Self-checking bench for the MD4 byte-stream digest block.
// ----------------------------------------------------------------------------
// A short table of messages runs first. The empty-message digest is typed in,
// and every other digest comes from a behavioral MD4 model kept in the bench.
// Then come messages whose lengths sit on the padding and block boundaries,
// followed by messages of random length and content. Both stream sides idle
// in random bursts, and the sender pauses once until every digest has been
// taken. Each returned digest is compared half by half with the oldest
// pending prediction.
// ----------------------------------------------------------------------------
module tb_md4_message_digest;
    import md4_pkg::*;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0]  PAD_MARK      = 8'h80;
    localparam logic [31:0] ROUND2_ADDEND = 32'h5a827999;
    localparam logic [31:0] ROUND3_ADDEND = 32'h6ed9eba1;
    // rotate amounts, four per round, first round in the low bits
    localparam logic [59:0] ROT_TABLE = {5'd15, 5'd11, 5'd9, 5'd3,
                                         5'd13, 5'd9,  5'd5, 5'd3,
                                         5'd19, 5'd11, 5'd7, 5'd3};

    // MD4 of the empty string, digest byte 0 in bits 7:0
    localparam logic [127:0] EMPTY_DIGEST = {64'hc089c0e0d7593cb7, 64'h31e96ad1e0cfd631};

    localparam int ITEM_TARGET    = 2000;
    localparam int QUIET_FROM     = 1700;
    localparam int PAUSE_AT_MSG   = 12;
    localparam int DRAIN_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int BOUNDARY_COUNT = 10;
    localparam logic [99:0] BOUNDARY_LENS = {10'd128, 10'd127, 10'd120, 10'd119, 10'd65,
                                             10'd64,  10'd63,  10'd57,  10'd56,  10'd55};

    typedef struct packed {
        logic         cmd;
        logic [7:0]   data;
        logic         known;
        logic [127:0] digest;
    } stim_row_t;

    localparam int ROW_COUNT = 13;
    stim_row_t directed_rows [ROW_COUNT] = '{
        '{CMD_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
        '{CMD_ABSORB, 8'h00, 1'b0, 128'h0},
        '{CMD_ABSORB, 8'hff, 1'b0, 128'h0},
        '{CMD_ABSORB, 8'h01, 1'b0, 128'h0},
        '{CMD_ABSORB, 8'h80, 1'b0, 128'h0},
        '{CMD_FINISH, 8'hff, 1'b0, 128'h0},
        '{CMD_FINISH, 8'h5a, 1'b1, EMPTY_DIGEST},
        '{CMD_ABSORB, 8'h61, 1'b0, 128'h0},
        '{CMD_FINISH, 8'h00, 1'b0, 128'h0},
        '{CMD_ABSORB, 8'h61, 1'b0, 128'h0},
        '{CMD_ABSORB, 8'h62, 1'b0, 128'h0},
        '{CMD_ABSORB, 8'h63, 1'b0, 128'h0},
        '{CMD_FINISH, 8'h00, 1'b0, 128'h0}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [DIGEST_W-1:0] m_tdata;

    // bench-side tags that travel with the item being offered
    logic         s_known;
    logic [127:0] s_known_digest;

    // behavioral MD4 state
    logic [31:0]  chain_words [4];
    logic [7:0]   block_bytes [64];
    int unsigned  block_fill;
    logic [63:0]  message_bits;

    logic [127:0] expected_digests [$];
    logic [127:0] predicted_digest;
    logic [127:0] wanted_digest;
    int           mismatch_count;
    int           idle_cycles;
    int           items_sent;
    bit           quiet_phase;
    bit           sender_gaps;

    md4_message_digest dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void md4_model_clear();
        int unsigned j;
        chain_words[0] = 32'h67452301;
        chain_words[1] = 32'hefcdab89;
        chain_words[2] = 32'h98badcfe;
        chain_words[3] = 32'h10325476;
        for (j = 0; j < 64; j++) block_bytes[j] = 8'h00;
        block_fill   = 0;
        message_bits = 64'd0;
    endfunction

    function automatic void md4_compress_block();
        logic [31:0] msg [16];
        logic [31:0] v [4];
        logic [31:0] x, y, z, f, k, sum;
        int unsigned r, j, slot, m, s;
        for (j = 0; j < 16; j++)
            msg[j] = {block_bytes[4*j+3], block_bytes[4*j+2],
                      block_bytes[4*j+1], block_bytes[4*j]};
        for (j = 0; j < 4; j++) v[j] = chain_words[j];
        for (r = 0; r < 48; r++) begin
            // slots rotate A, D, C, B through each group of four steps
            slot = (4 - r % 4) % 4;
            x = v[(slot + 1) % 4];
            y = v[(slot + 2) % 4];
            z = v[(slot + 3) % 4];
            j = r % 16;
            case (r / 16)
                0: begin
                    f = z ^ (x & (y ^ z));
                    k = 32'h0;
                    m = j;
                end
                1: begin
                    f = (x & y) | (x & z) | (y & z);
                    k = ROUND2_ADDEND;
                    m = (j % 4) * 4 + j / 4;
                end
                default: begin
                    f = x ^ y ^ z;
                    k = ROUND3_ADDEND;
                    // bit-reversed word order
                    m = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
                end
            endcase
            s = 32'(ROT_TABLE[5*(4*(r/16) + r%4) +: 5]);
            sum = v[slot] + f + msg[m] + k;
            v[slot] = (sum << s) | (sum >> (32 - s));
        end
        for (j = 0; j < 4; j++) chain_words[j] = chain_words[j] + v[j];
        for (j = 0; j < 64; j++) block_bytes[j] = 8'h00;
        block_fill = 0;
    endfunction

    // Advance the model by one transaction; return 1 when a digest comes out.
    function automatic bit md4_predict_step(input logic cmd, input logic [7:0] data,
                                            output logic [127:0] digest);
        int unsigned j;
        digest = '0;
        if (cmd == CMD_ABSORB) begin
            block_bytes[block_fill] = data;
            block_fill++;
            message_bits = message_bits + 64'd8;
            if (block_fill == 64) md4_compress_block();
            return 1'b0;
        end
        block_bytes[block_fill] = PAD_MARK;
        // no room left for the length: pad goes out in a block of its own
        if (block_fill >= 56) md4_compress_block();
        for (j = 0; j < 8; j++) block_bytes[56 + j] = message_bits[8*j +: 8];
        md4_compress_block();
        digest = {chain_words[3], chain_words[2], chain_words[1], chain_words[0]};
        md4_model_clear();
        return 1'b1;
    endfunction

    // Predict on input transactions, check output transactions, watch for hangs.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (md4_predict_step(s_tuser, s_tdata, predicted_digest))
                    expected_digests.push_back(s_known ? s_known_digest : predicted_digest);
            end
            if (m_tvalid && m_tready) begin
                if (expected_digests.size() == 0) begin
                    $display("%0t: digest with none pending: actual %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    wanted_digest = expected_digests.pop_front();
                    if (m_tdata[63:0] !== wanted_digest[63:0]) begin
                        $display("%0t: digest_first expected %h actual %h",
                                 $time, wanted_digest[63:0], m_tdata[63:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[127:64] !== wanted_digest[127:64]) begin
                        $display("%0t: digest_second expected %h actual %h",
                                 $time, wanted_digest[127:64], m_tdata[127:64]);
                        mismatch_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // Result side: stall in short bursts, with stretches of steady ready.
    initial begin
        int  stall_left;
        bit  ready_gaps;
        stall_left = 0;
        ready_gaps = 1'b1;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 63) == 0) ready_gaps = !ready_gaps;
            if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else if (!quiet_phase && ready_gaps && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                m_tready   = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offer one transaction at the falling edge and hold it until taken.
    task automatic send_item(input logic cmd, input logic [7:0] data,
                             input logic known, input logic [127:0] digest);
        int gap;
        if (items_sent >= QUIET_FROM) quiet_phase = 1'b1;
        if (!quiet_phase && sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid       = 1'b1;
        s_tuser        = cmd;
        s_tdata        = data;
        s_known        = known;
        s_known_digest = digest;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    initial begin
        int          row;
        int          msg_idx;
        int          msg_len;
        int          n;
        logic [7:0]  fill_byte;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tuser        = CMD_ABSORB;
        s_known        = 1'b0;
        s_known_digest = '0;
        aresetn        = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        items_sent     = 0;
        quiet_phase    = 1'b0;
        sender_gaps    = 1'b1;
        md4_model_clear();
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        for (row = 0; row < ROW_COUNT; row++)
            send_item(directed_rows[row].cmd, directed_rows[row].data,
                      directed_rows[row].known, directed_rows[row].digest);

        msg_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (msg_idx == PAUSE_AT_MSG) begin
                // hold off until the result side has drained
                s_tvalid = 1'b0;
                while (expected_digests.size() != 0) @(negedge aclk);
            end
            // walk the padding and block boundaries first, then go random
            if (msg_idx < BOUNDARY_COUNT) begin
                msg_len = int'(BOUNDARY_LENS[10*msg_idx +: 10]);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: msg_len = $urandom_range(0, 12);
                    4, 5, 6:    msg_len = int'(BOUNDARY_LENS[10*$urandom_range(0, 9) +: 10]);
                    7, 8:       msg_len = $urandom_range(13, 130);
                    default:    msg_len = $urandom_range(131, 300);
                endcase
            end
            sender_gaps = ($urandom_range(0, 2) != 0);
            for (n = 0; n < msg_len; n++) begin
                fill_byte = 8'($urandom_range(0, 255));
                send_item(CMD_ABSORB, fill_byte, 1'b0, '0);
            end
            // byte is ignored on finish; keep it random anyway
            fill_byte = 8'($urandom_range(0, 255));
            send_item(CMD_FINISH, fill_byte, 1'b0, '0);
            msg_idx++;
        end

        s_tvalid = 1'b0;
        while (expected_digests.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[md4_message_digest.f]
rtl/md4_pkg.sv
rtl/md4_ctrl.sv
rtl/md4_datapath.sv
rtl/md4_message_digest.sv
rtl/md4_checker.sv
bench/tb_md4_message_digest.sv
